FILE: hw/rtl/idl_pkg.sv
// Shared constants, types and coefficient table for the interpolated delay line.
`timescale 1ns / 1ps
package idl_pkg;

  localparam int ADDR_BITS   = 12;
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 16;
  localparam int DELAY_BITS  = ADDR_BITS + FRAC_BITS;
  localparam int RING_DEPTH  = 1 << ADDR_BITS;
  localparam int MODE_BITS   = 3;
  localparam int OP_BITS     = 2;
  localparam int COEF_W      = 30;
  localparam int ACC_W       = 34;
  localparam int MB_W        = 32;
  localparam int PROD_W      = ACC_W + MB_W;
  localparam int STEP_W      = 4;
  localparam int COEF_SHIFT  = 30;

  localparam logic [OP_BITS-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_BITS-1:0] OP_READ  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

  localparam logic [MODE_BITS-1:0] MODE_INT     = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_LINEAR  = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_WATTE   = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_HERMITE = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_OPTIMAL = 3'd4;

  typedef enum logic [1:0] {MA_DIFF, MA_COEF, MA_ACC, MA_EO} mul_a_t;
  typedef enum logic [1:0] {MB_F, MB_X, MB_Z, MB_K} mul_b_t;
  typedef enum logic [2:0] {
    AO_NONE, AO_LIN, AO_HORN, AO_SUMLD, AO_COEF, AO_HALF, AO_Y0
  } acc_op_t;

  typedef struct packed {
    logic                 wr_en;
    logic                 head_clr;
    logic                 clr_en;
    logic                 dly_ld;
    logic                 rd_en;
    logic [1:0]           rd_idx;
    logic                 cap_en;
    logic [1:0]           cap_idx;
    logic                 coef_ld;
    logic [MODE_BITS-1:0] mode;
    logic                 mul_en;
    mul_a_t               mul_a;
    logic [1:0]           mul_idx;
    mul_b_t               mul_b;
    logic [2:0]           k_idx;
    acc_op_t              acc_op;
    logic [1:0]           add_idx;
    logic                 out_ld;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
  } stat_t;

  // Optimal-2x cubic constants, signed Q2.30.
  function automatic logic signed [MB_W-1:0] opt_k(input logic [2:0] idx);
    logic signed [MB_W-1:0] k;
    case (idx)
      3'd0:    k = 32'sd492514324;
      3'd1:    k = 32'sd44360590;
      3'd2:    k = 32'sd516126486;
      3'd3:    k = 32'sd188741539;
      3'd4:    k = -32'sd264339138;
      3'd5:    k = 32'sd264291104;
      3'd6:    k = -32'sd386879114;
      default: k = 32'sd109253078;
    endcase
    return k;
  endfunction

endpackage

FILE: hw/rtl/idl_ctrl.sv
// Controller state machine: handshakes, clearing pass and interpolation sequencing.
`timescale 1ns / 1ps
module idl_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [idl_pkg::OP_BITS-1:0]     in_operation,
  output logic                            in_stall,
  output logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [idl_pkg::MODE_BITS-1:0]   cfg_interp_mode,
  output idl_pkg::cmd_t                   cmd,
  input  idl_pkg::stat_t                  stat
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_RD    = 6'b000100,
    ST_COEF  = 6'b001000,
    ST_CALC  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [idl_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic [idl_pkg::MODE_BITS-1:0]   mode_r, mode_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            accept;
  logic                            calc_last;
  logic [idl_pkg::STEP_W-1:0]      last_step;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  always_comb begin
    case (mode_r)
      idl_pkg::MODE_LINEAR:  last_step = 4'd2;
      idl_pkg::MODE_WATTE:   last_step = 4'd5;
      idl_pkg::MODE_HERMITE: last_step = 4'd7;
      idl_pkg::MODE_OPTIMAL: last_step = 4'd15;
      default:               last_step = 4'd1;
    endcase
  end
  assign calc_last = (step_r == last_step);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.mode      = mode_r;
    cmd.mul_a     = idl_pkg::MA_DIFF;
    cmd.mul_b     = idl_pkg::MB_F;
    cmd.acc_op    = idl_pkg::AO_NONE;
    if (cfg_valid) begin
      mode_nxt = cfg_interp_mode;
    end
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_operation)
            idl_pkg::OP_WRITE: cmd.wr_en = 1'b1;
            idl_pkg::OP_CLEAR: cmd.head_clr = 1'b1;
            idl_pkg::OP_READ: begin
              cmd.dly_ld = 1'b1;
              step_nxt   = '0;
              state_nxt  = ST_RD;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        // issue four tap reads, capture each in the cycle after its read
        if (step_r < 4'd4) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_idx = step_r[1:0];
        end
        if (step_r != 4'd0) begin
          cmd.cap_en  = 1'b1;
          cmd.cap_idx = 2'(step_r - 4'd1);
        end
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd4) begin
          state_nxt = ST_COEF;
        end
      end
      ST_COEF: begin
        cmd.coef_ld = 1'b1;
        step_nxt    = '0;
        state_nxt   = ST_CALC;
      end
      ST_CALC: begin
        step_nxt = step_r + 4'd1;
        case (mode_r)
          idl_pkg::MODE_LINEAR: begin
            if (step_r == 4'd0) begin
              cmd.mul_en = 1'b1;
            end
            if (step_r == 4'd1) begin
              cmd.acc_op = idl_pkg::AO_LIN;
            end
          end
          idl_pkg::MODE_WATTE: begin
            cmd.mul_b = idl_pkg::MB_X;
            case (step_r)
              4'd0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_a   = idl_pkg::MA_COEF;
                cmd.mul_idx = 2'd2;
              end
              4'd1: begin
                cmd.acc_op  = idl_pkg::AO_HORN;
                cmd.add_idx = 2'd1;
              end
              4'd2: begin
                cmd.mul_en = 1'b1;
                cmd.mul_a  = idl_pkg::MA_ACC;
              end
              4'd3: begin
                cmd.acc_op  = idl_pkg::AO_HORN;
                cmd.add_idx = 2'd0;
              end
              4'd4: cmd.acc_op = idl_pkg::AO_HALF;
              default: ;
            endcase
          end
          idl_pkg::MODE_HERMITE: begin
            cmd.mul_b = idl_pkg::MB_X;
            case (step_r)
              4'd0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_a   = idl_pkg::MA_COEF;
                cmd.mul_idx = 2'd3;
              end
              4'd1: begin
                cmd.acc_op  = idl_pkg::AO_HORN;
                cmd.add_idx = 2'd2;
              end
              4'd2, 4'd4: begin
                cmd.mul_en = 1'b1;
                cmd.mul_a  = idl_pkg::MA_ACC;
              end
              4'd3: begin
                cmd.acc_op  = idl_pkg::AO_HORN;
                cmd.add_idx = 2'd1;
              end
              4'd5: begin
                cmd.acc_op  = idl_pkg::AO_HORN;
                cmd.add_idx = 2'd0;
              end
              4'd6: cmd.acc_op = idl_pkg::AO_HALF;
              default: ;
            endcase
          end
          idl_pkg::MODE_OPTIMAL: begin
            // coefficients: two products summed per coefficient, then Horner in z
            if (step_r <= 4'd7) begin
              cmd.mul_en  = 1'b1;
              cmd.mul_a   = idl_pkg::MA_EO;
              cmd.mul_b   = idl_pkg::MB_K;
              cmd.k_idx   = step_r[2:0];
              cmd.mul_idx = {step_r[0], step_r[1]};
              if (step_r[0]) begin
                cmd.acc_op = idl_pkg::AO_SUMLD;
              end
            end
            if (!step_r[0] && step_r >= 4'd2 && step_r <= 4'd8) begin
              cmd.acc_op  = idl_pkg::AO_COEF;
              cmd.add_idx = 2'(step_r[3:1] - 3'd1);
            end
            case (step_r)
              4'd9: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_a   = idl_pkg::MA_COEF;
                cmd.mul_b   = idl_pkg::MB_Z;
                cmd.mul_idx = 2'd3;
              end
              4'd11, 4'd13: begin
                cmd.mul_en = 1'b1;
                cmd.mul_a  = idl_pkg::MA_ACC;
                cmd.mul_b  = idl_pkg::MB_Z;
              end
              4'd10: begin
                cmd.acc_op  = idl_pkg::AO_HORN;
                cmd.add_idx = 2'd2;
              end
              4'd12: begin
                cmd.acc_op  = idl_pkg::AO_HORN;
                cmd.add_idx = 2'd1;
              end
              4'd14: begin
                cmd.acc_op  = idl_pkg::AO_HORN;
                cmd.add_idx = 2'd0;
              end
              default: ;
            endcase
          end
          default: begin
            if (step_r == 4'd0) begin
              cmd.acc_op = idl_pkg::AO_Y0;
            end
          end
        endcase
        if (calc_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      step_r      <= '0;
      mode_r      <= idl_pkg::MODE_INT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/idl_datapath.sv
// Datapath: sample ring memory, tap registers, coefficient logic and shared multiplier.
`timescale 1ns / 1ps
module idl_datapath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  idl_pkg::cmd_t                           cmd,
  output idl_pkg::stat_t                          stat,
  input  logic signed [idl_pkg::SAMPLE_BITS-1:0]  in_sample_in,
  input  logic [idl_pkg::DELAY_BITS-1:0]          in_delay_q,
  output logic signed [idl_pkg::SAMPLE_BITS-1:0]  sample_out
);

  localparam int SB  = idl_pkg::SAMPLE_BITS;
  localparam int AB  = idl_pkg::ADDR_BITS;
  localparam int FB  = idl_pkg::FRAC_BITS;
  localparam int CW  = idl_pkg::COEF_W;
  localparam int AW  = idl_pkg::ACC_W;
  localparam int BW  = idl_pkg::MB_W;
  localparam int PW  = idl_pkg::PROD_W;
  localparam logic signed [PW-1:0] HALF_F = PW'(1) <<< (FB - 1);
  localparam logic signed [PW-1:0] HALF_C = PW'(1) <<< (idl_pkg::COEF_SHIFT - 1);
  localparam logic signed [AW-1:0] SAT_MAX = AW'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic signed [AW-1:0] SAT_MIN = -SAT_MAX - AW'(1);

  logic signed [SB-1:0] mem [idl_pkg::RING_DEPTH];
  logic signed [SB-1:0] rdata_r;
  logic [AB-1:0]        head_r, clr_cnt_r;
  logic [idl_pkg::DELAY_BITS-1:0] dly_r;
  logic signed [SB-1:0] tap_r  [4];
  logic signed [CW-1:0] coef_r [4];
  logic signed [CW-1:0] eo_r   [4];
  logic signed [PW-1:0] prod_r, sum_r;
  logic signed [AW-1:0] acc_r;
  logic signed [SB-1:0] out_r;

  logic                 mem_we;
  logic [AB-1:0]        waddr, raddr;
  logic signed [SB-1:0] wdata;
  logic signed [CW-1:0] ym1, y0, y1, y2;
  logic [FB-1:0]        frac;
  logic [FB:0]          x;
  logic signed [FB+1:0] z;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] p_sh, c_sh;
  logic signed [AW-1:0] addend;
  logic signed [SB-1:0] sat;

  assign stat.clr_done = (clr_cnt_r == {AB{1'b1}});

  // Memory: clearing pass, sample writes and tap reads
  assign mem_we = cmd.clr_en || cmd.wr_en;
  assign waddr  = cmd.clr_en ? clr_cnt_r : head_r;
  assign wdata  = cmd.clr_en ? '0 : in_sample_in;
  assign raddr  = head_r - dly_r[idl_pkg::DELAY_BITS-1:FB] + AB'(cmd.rd_idx) - AB'(2);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.clr_en) begin
        clr_cnt_r <= clr_cnt_r + AB'(1);
      end
      if (cmd.head_clr) begin
        head_r <= '0;
      end else if (cmd.wr_en && !cmd.clr_en) begin
        head_r <= head_r + AB'(1);
      end
    end
  end

  assign ym1  = {{(CW-SB){tap_r[0][SB-1]}}, tap_r[0]};
  assign y0   = {{(CW-SB){tap_r[1][SB-1]}}, tap_r[1]};
  assign y1   = {{(CW-SB){tap_r[2][SB-1]}}, tap_r[2]};
  assign y2   = {{(CW-SB){tap_r[3][SB-1]}}, tap_r[3]};
  assign frac = dly_r[FB-1:0];
  assign x    = {1'b1, {FB{1'b0}}} - {1'b0, frac};
  assign z    = $signed({1'b0, x}) - $signed((FB+2)'(1) << (FB - 1));

  always_comb begin
    case (cmd.mul_a)
      idl_pkg::MA_DIFF: mul_a = AW'(y0 - y1);
      idl_pkg::MA_COEF: mul_a = {{(AW-CW){coef_r[cmd.mul_idx][CW-1]}}, coef_r[cmd.mul_idx]};
      idl_pkg::MA_ACC:  mul_a = acc_r;
      default:          mul_a = {{(AW-CW){eo_r[cmd.mul_idx][CW-1]}}, eo_r[cmd.mul_idx]};
    endcase
    case (cmd.mul_b)
      idl_pkg::MB_F: mul_b = {{(BW-FB){1'b0}}, frac};
      idl_pkg::MB_X: mul_b = {{(BW-FB-1){1'b0}}, x};
      idl_pkg::MB_Z: mul_b = {{(BW-FB-2){z[FB+1]}}, z};
      default:       mul_b = idl_pkg::opt_k(cmd.k_idx);
    endcase
  end

  assign p_sh   = (prod_r + HALF_F) >>> FB;
  assign c_sh   = (sum_r + prod_r + HALF_C) >>> idl_pkg::COEF_SHIFT;
  assign addend = {{(AW-CW){coef_r[cmd.add_idx][CW-1]}}, coef_r[cmd.add_idx]};

  always_comb begin
    if (acc_r > SAT_MAX) begin
      sat = SAT_MAX[SB-1:0];
    end else if (acc_r < SAT_MIN) begin
      sat = SAT_MIN[SB-1:0];
    end else begin
      sat = acc_r[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dly_ld) begin
      dly_r <= in_delay_q;
    end
    if (cmd.cap_en) begin
      tap_r[cmd.cap_idx] <= rdata_r;
    end
    if (cmd.coef_ld) begin
      case (cmd.mode)
        idl_pkg::MODE_WATTE: begin
          coef_r[0] <= y0 <<< 1;
          coef_r[1] <= (y1 <<< 1) + y1 - y0 - ym1 - y2;
          coef_r[2] <= ym1 + y2 - y0 - y1;
          coef_r[3] <= '0;
        end
        default: begin
          coef_r[0] <= y0 <<< 1;
          coef_r[1] <= y1 - ym1;
          coef_r[2] <= (ym1 <<< 1) - (y0 <<< 2) - y0 + (y1 <<< 2) - y2;
          coef_r[3] <= (y2 - ym1) + ((y0 - y1) <<< 1) + (y0 - y1);
        end
      endcase
      eo_r[0] <= y1 + y0;
      eo_r[1] <= y1 - y0;
      eo_r[2] <= y2 + ym1;
      eo_r[3] <= y2 - ym1;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    case (cmd.acc_op)
      idl_pkg::AO_LIN:   acc_r <= {{(AW-CW){y1[CW-1]}}, y1} + p_sh[AW-1:0];
      idl_pkg::AO_HORN:  acc_r <= p_sh[AW-1:0] + addend;
      idl_pkg::AO_SUMLD: sum_r <= prod_r;
      idl_pkg::AO_COEF:  coef_r[cmd.add_idx] <= c_sh[CW-1:0];
      idl_pkg::AO_HALF:  acc_r <= (acc_r + AW'(1)) >>> 1;
      idl_pkg::AO_Y0:    acc_r <= {{(AW-CW){y0[CW-1]}}, y0};
      default: ;
    endcase
    if (cmd.out_ld) begin
      out_r <= sat;
    end
  end

  assign sample_out = out_r;

endmodule

FILE: hw/rtl/interpolated_delay_line.sv
// Top level of the interpolated delay line: controller plus datapath.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per operation:
//   write stores in_sample_in at the head and advances it, clear returns the
//   head to zero, read takes in_delay_q (12 integer, 16 fraction bits) and
//   produces exactly one out_sample_out transaction. Writes and clears give
//   no output. A read fetches the four taps through the single ring port,
//   loads the coefficients, then runs the multiply sequence of the mode
//   (integer tap, linear, Watte, Hermite or optimal cubic) on the one
//   shared multiplier and loads the output register; one read at a time.
//   cfg_interp_mode is written through cfg_valid / cfg_ready (always ready);
//   the user must see that it is written only while the block is idle, as
//   the block itself does not enforce this.
//   After reset a clearing pass zeroes the 4096-entry ring, one entry per
//   cycle; in_stall stays high until the pass is done. Mode resets to the
//   integer tap.
//   If the receiver stalls, the result holds in the output register and the
//   next read waits for it only at its final cycle.
module interpolated_delay_line (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [idl_pkg::OP_BITS-1:0]             in_operation,
  input  logic signed [idl_pkg::SAMPLE_BITS-1:0]  in_sample_in,
  input  logic [idl_pkg::DELAY_BITS-1:0]          in_delay_q,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [idl_pkg::SAMPLE_BITS-1:0]  out_sample_out,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [idl_pkg::MODE_BITS-1:0]           cfg_interp_mode
);

  // command and status between controller and datapath
  idl_pkg::cmd_t  cmd;
  idl_pkg::stat_t stat;

  idl_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_operation    (in_operation),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_interp_mode (cfg_interp_mode),
    .cmd             (cmd),
    .stat            (stat)
  );

  idl_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_sample_in (in_sample_in),
    .in_delay_q   (in_delay_q),
    .sample_out   (out_sample_out)
  );

endmodule

FILE: test/tb_interpolated_delay_line.sv
// Self-checking testbench for the interpolated delay line: predicts every read and checks it.
`timescale 1ns / 1ps
module tb_interpolated_delay_line;

  localparam int AB = idl_pkg::ADDR_BITS;
  localparam int SB = idl_pkg::SAMPLE_BITS;
  localparam int FB = idl_pkg::FRAC_BITS;
  localparam int DB = idl_pkg::DELAY_BITS;
  localparam int MB = idl_pkg::MODE_BITS;
  localparam int OB = idl_pkg::OP_BITS;
  localparam int RING = 1 << AB;
  localparam longint SMAX = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  // Operation code with no defined meaning.
  localparam logic [OB-1:0] OP_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OB-1:0] in_operation = idl_pkg::OP_WRITE;
  logic signed [SB-1:0] in_sample_in = '0;
  logic [DB-1:0] in_delay_q = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SB-1:0] out_sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MB-1:0] cfg_interp_mode = idl_pkg::MODE_INT;

  interpolated_delay_line i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_sample_in   (in_sample_in),
    .in_delay_q     (in_delay_q),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_interp_mode(cfg_interp_mode)
  );

  // 4 ns clock: two ns high, two ns low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the block: ring contents, head and mode.
  longint ring_model [RING];
  logic [AB-1:0] head_model;
  logic [MB-1:0] mode_model;
  logic signed [SB-1:0] pending_samples [$];

  int mismatches = 0;
  int reads_checked = 0;
  int items_sent = 0;
  bit stall_rx_enable = 1'b0;

  // Optimal cubic table, signed Q2.30.
  longint opt_coef [8] = '{492514324, 44360590, 516126486, 188741539,
                           -264339138, 264291104, -386879114, 109253078};

  // Round half up after dividing by 2^s; >>> on longint is an arithmetic floor.
  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint ring_tap(logic [AB-1:0] idx);
    return ring_model[idx];
  endfunction

  function automatic logic signed [SB-1:0] interpolate(logic [DB-1:0] dq);
    logic [AB-1:0] r;
    longint f, x, z, ym1, y0, y1, y2, acc, c0, c1, c2, c3, e1, o1, e2, o2;
    f = longint'(dq[FB-1:0]);
    r = head_model - AB'(1) - dq[DB-1:FB];
    ym1 = ring_tap(r - AB'(1));
    y0 = ring_tap(r);
    y1 = ring_tap(r + AB'(1));
    y2 = ring_tap(r + AB'(2));
    x = (64'sd1 <<< FB) - f;
    case (mode_model)
      idl_pkg::MODE_LINEAR: acc = y1 + round_shift((y0 - y1) * f, FB);
      idl_pkg::MODE_WATTE: begin
        c1 = 3 * y1 - y0 - ym1 - y2;
        c2 = ym1 + y2 - y0 - y1;
        acc = round_shift(c2 * x, FB) + c1;
        acc = round_shift(acc * x, FB) + 2 * y0;
        acc = round_shift(acc, 1);
      end
      idl_pkg::MODE_HERMITE: begin
        c1 = y1 - ym1;
        c2 = 2 * ym1 - 5 * y0 + 4 * y1 - y2;
        c3 = (y2 - ym1) + 3 * (y0 - y1);
        acc = round_shift(c3 * x, FB) + c2;
        acc = round_shift(acc * x, FB) + c1;
        acc = round_shift(acc * x, FB) + 2 * y0;
        acc = round_shift(acc, 1);
      end
      idl_pkg::MODE_OPTIMAL: begin
        e1 = y1 + y0; o1 = y1 - y0; e2 = y2 + ym1; o2 = y2 - ym1;
        c0 = round_shift(e1 * opt_coef[0] + e2 * opt_coef[1], idl_pkg::COEF_SHIFT);
        c1 = round_shift(o1 * opt_coef[2] + o2 * opt_coef[3], idl_pkg::COEF_SHIFT);
        c2 = round_shift(e1 * opt_coef[4] + e2 * opt_coef[5], idl_pkg::COEF_SHIFT);
        c3 = round_shift(o1 * opt_coef[6] + o2 * opt_coef[7], idl_pkg::COEF_SHIFT);
        z = x - (64'sd1 <<< (FB - 1));
        acc = round_shift(c3 * z, FB) + c2;
        acc = round_shift(acc * z, FB) + c1;
        acc = round_shift(acc * z, FB) + c0;
      end
      default: acc = y0;  // integer tap, and unused modes act the same
    endcase
    if (acc > SMAX) acc = SMAX;
    if (acc < SMIN) acc = SMIN;
    return acc[SB-1:0];
  endfunction

  // Update the shadow and queue the expected sample for a read.
  task automatic apply_operation(logic [OB-1:0] op,
                                 logic signed [SB-1:0] smp,
                                 logic [DB-1:0] dq);
    case (op)
      idl_pkg::OP_WRITE: begin
        ring_model[head_model] = longint'(smp);
        head_model = head_model + AB'(1);
      end
      idl_pkg::OP_CLEAR: head_model = '0;
      idl_pkg::OP_READ: pending_samples.push_back(interpolate(dq));
      default: ;  // unused code: no effect, no result
    endcase
  endtask

  // Half the time no gap, otherwise mostly a short one, now and then a long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one transaction; hold the payload until it is taken.
  // Valid stays high after acceptance so back-to-back transactions need no gap;
  // drop it before a gap or when draining.
  task automatic send_item(logic [OB-1:0] op,
                           logic signed [SB-1:0] smp,
                           logic [DB-1:0] dq, bit use_gaps);
    int g;
    g = use_gaps ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_sample_in <= smp;
    in_delay_q <= dq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_operation(op, smp, dq);
    items_sent++;
  endtask

  // Wait until every queued result has come, then let the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_mode(logic [MB-1:0] m);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_interp_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_model = m;
  endtask

  // Receiver: stall at random, compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", out_sample_out);
      end else begin
        if (out_sample_out !== pending_samples[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample_out mismatch: expected %0d actual %0d mode %0d",
                     pending_samples[0], out_sample_out, mode_model);
        end
        void'(pending_samples.pop_front());
        reads_checked++;
      end
    end
    out_stall <= stall_rx_enable ? (gap_len() != 0) : 1'b0;
  end

  function automatic logic [DB-1:0] pick_delay();
    logic [DB-1:0] d;
    d = DB'($urandom);
    // Most reads use short delays so that they hit freshly written samples.
    if ($urandom_range(0, 3) != 0) d[DB-1:FB] = AB'($urandom_range(0, 40));
    return d;
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return SMAX[SB-1:0];
      1: return SMIN[SB-1:0];
      default: return SB'($urandom);
    endcase
  endfunction

  // Extremes of samples and delays, every operation, ring wrap, unused codes.
  task automatic test_directed();
    send_item(idl_pkg::OP_READ, '0, '0, 1'b0);           // reads the cleared ring
    send_item(idl_pkg::OP_WRITE, SMAX[SB-1:0], '0, 1'b0);
    send_item(idl_pkg::OP_WRITE, SMIN[SB-1:0], '0, 1'b0);
    send_item(idl_pkg::OP_WRITE, SMAX[SB-1:0], '0, 1'b0);
    send_item(idl_pkg::OP_WRITE, SMIN[SB-1:0], '0, 1'b0);
    send_item(idl_pkg::OP_WRITE, 24'sh555555, '0, 1'b0);
    foreach (opt_coef[m]) begin
      if (m > 5) break;
      write_mode(m[MB-1:0]);
      send_item(idl_pkg::OP_READ, '0, {12'd1, 16'hFFFF}, 1'b0);
      send_item(idl_pkg::OP_READ, '0, {12'd2, 16'h8000}, 1'b0);
    end
    write_mode(idl_pkg::MODE_HERMITE);
    send_item(idl_pkg::OP_READ, '0, {DB{1'b1}}, 1'b0);  // wraps past the ring end
    send_item(idl_pkg::OP_READ, '0, {12'd0, 16'h0001}, 1'b0);
    send_item(OP_SPARE, 24'sh7AAAAA, '1, 1'b0);          // unused operation
    send_item(idl_pkg::OP_CLEAR, '0, '0, 1'b0);
    send_item(idl_pkg::OP_READ, '0, {12'd3, 16'h4000}, 1'b0);
  endtask

  // Random mix of writes and reads, with clears and unused codes mixed in.
  task automatic test_random(int count, logic [MB-1:0] m);
    int n, p;
    write_mode(m);
    n = 0;
    while (n < count) begin
      p = $urandom_range(0, 99);
      if (p < 55) send_item(idl_pkg::OP_WRITE, pick_sample(), '0, 1'b1);
      else if (p < 95) send_item(idl_pkg::OP_READ, '0, pick_delay(), 1'b1);
      else if (p < 98) send_item(idl_pkg::OP_CLEAR, '0, '0, 1'b1);
      else send_item(OP_SPARE, pick_sample(), pick_delay(), 1'b1);
      n++;
      // Halfway through, hold off until all results are home.
      if (n == count / 2) drain_results();
    end
  endtask

  // Clear, refill, then read with delays whose taps straddle ring index zero.
  task automatic test_ring_wrap();
    write_mode(idl_pkg::MODE_OPTIMAL);
    send_item(idl_pkg::OP_CLEAR, '0, '0, 1'b0);
    repeat (250) send_item(idl_pkg::OP_WRITE, pick_sample(), '0, 1'b0);
    repeat (50)
      send_item(idl_pkg::OP_READ, '0,
                {AB'($urandom_range(240, 255)), FB'($urandom)}, 1'b1);
  endtask

  initial begin
    foreach (ring_model[i]) ring_model[i] = 0;
    head_model = '0;
    mode_model = idl_pkg::MODE_INT;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    stall_rx_enable = 1'b1;
    for (int k = 0; k < 8; k++) test_random(160, k[MB-1:0]);
    test_random(100, idl_pkg::MODE_OPTIMAL);
    test_ring_wrap();
    drain_results();
    $display("Covered %0d transactions and %0d checked reads across all modes,",
             items_sent, reads_checked);
    $display("including saturation, ring wrap, clears and unused codes.");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("Timeout");
    $display("Regression FAIL");
    $finish;
  end

endmodule
